>>> sv/ccud_pkg.sv
// package: shared types, op codes and calendar helpers for the calendar clock
`timescale 1ns / 1ps

package ccud_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int OP_W     = 2;
  localparam int TIME_W   = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;

  localparam logic [YEAR_W-1:0]   YEAR_MAX    = 14'd9999;
  localparam logic [MONTH_W-1:0]  MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0]  MONTH_LAST  = 4'd12;
  localparam logic [MONTH_W-1:0]  MONTH_FEB   = 4'd2;
  localparam logic [DAY_W-1:0]    DAY_FIRST   = 5'd1;
  localparam logic [HOUR_W-1:0]   HOUR_LAST   = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
  localparam logic [SECOND_W-1:0] SECOND_LAST = 6'd59;

  // y / 100 as (y * 5243) >> 19, exact for any 14-bit year
  localparam int                 RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
  localparam int                 RECIP_SHIFT = 19;
  localparam int                 PROD_W      = YEAR_W + RECIP_W;
  // multiples of 100 leave a fraction below 2^12, all others at least 5243
  localparam int                 FRAC_SMALL  = 12;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_BACK = 2'd1,
    OP_FWD  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } time_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [PROD_W-1:0] prod;
    logic              div100;
    logic              div400;
    prod   = {{RECIP_W{1'b0}}, y} * {{YEAR_W{1'b0}}, RECIP_100};
    div100 = (prod[RECIP_SHIFT-1:FRAC_SMALL] == '0);
    div400 = div100 && (prod[RECIP_SHIFT+1:RECIP_SHIFT] == 2'b00);
    return div400 || ((y[1:0] == 2'b00) && !div100);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

>>> sv/ccud_step.sv
// next-time logic: load check and one-second forward and back steps
`timescale 1ns / 1ps

module ccud_step
  import ccud_pkg::*;
(
  input  time_t cur,
  input  op_t   op,
  input  time_t load,
  output time_t nxt,
  output logic  accepted
);

  logic             cur_leap;
  logic             load_leap;
  logic [DAY_W-1:0] cur_len;
  logic [DAY_W-1:0] load_len;
  logic [DAY_W-1:0] prev_len;
  logic             load_ok;
  time_t            fwd;
  time_t            back;

  assign cur_leap  = is_leap(cur.year);
  assign load_leap = is_leap(load.year);
  assign cur_len   = month_len(cur.month, cur_leap);
  assign load_len  = month_len(load.month, load_leap);
  // previous month within the same year, december is 31 days anyway
  assign prev_len  = month_len(cur.month - MONTH_FIRST, cur_leap);

  assign load_ok = (load.year <= YEAR_MAX)
                && (load.month >= MONTH_FIRST) && (load.month <= MONTH_LAST)
                && (load.day >= DAY_FIRST) && (load.day <= load_len)
                && (load.hour <= HOUR_LAST)
                && (load.minute <= MINUTE_LAST)
                && (load.second <= SECOND_LAST);

  always_comb begin
    fwd = cur;
    if (cur.second < SECOND_LAST) begin
      fwd.second = cur.second + 1'b1;
    end else begin
      fwd.second = '0;
      if (cur.minute < MINUTE_LAST) begin
        fwd.minute = cur.minute + 1'b1;
      end else begin
        fwd.minute = '0;
        if (cur.hour < HOUR_LAST) begin
          fwd.hour = cur.hour + 1'b1;
        end else begin
          fwd.hour = '0;
          if (cur.day < cur_len) begin
            fwd.day = cur.day + 1'b1;
          end else begin
            fwd.day = DAY_FIRST;
            if (cur.month < MONTH_LAST) begin
              fwd.month = cur.month + 1'b1;
            end else begin
              fwd.month = MONTH_FIRST;
              fwd.year  = (cur.year >= YEAR_MAX) ? '0 : cur.year + 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    back = cur;
    if (cur.second > '0) begin
      back.second = cur.second - 1'b1;
    end else begin
      back.second = SECOND_LAST;
      if (cur.minute > '0) begin
        back.minute = cur.minute - 1'b1;
      end else begin
        back.minute = MINUTE_LAST;
        if (cur.hour > '0) begin
          back.hour = cur.hour - 1'b1;
        end else begin
          back.hour = HOUR_LAST;
          if (cur.day > DAY_FIRST) begin
            back.day = cur.day - 1'b1;
          end else if (cur.month > MONTH_FIRST) begin
            back.month = cur.month - 1'b1;
            back.day   = prev_len;
          end else begin
            back.month = MONTH_LAST;
            back.year  = (cur.year == '0) ? YEAR_MAX : cur.year - 1'b1;
            back.day   = month_len(MONTH_LAST, 1'b0);
          end
        end
      end
    end
  end

  always_comb begin
    unique case (op)
      OP_LOAD: begin
        nxt      = load_ok ? load : cur;
        accepted = load_ok;
      end
      OP_BACK: begin
        nxt      = back;
        accepted = 1'b1;
      end
      OP_FWD: begin
        nxt      = fwd;
        accepted = 1'b1;
      end
      default: begin
        nxt      = cur;
        accepted = 1'b0;
      end
    endcase
  end

endmodule

>>> sv/calendar_clock_up_down_top.sv
// top level: stream ports, input and result registers, time registers
`timescale 1ns / 1ps

// Gregorian calendar clock (year 0 to 9999, wrapping) that takes one item per
// clock while results are accepted: a load, a one-second step back or a
// one-second step forward, chosen by s_tuser. Every item returns one result with
// the time after it and an accepted flag (0 only for an invalid load or an
// unused op code, which leave the time as it was). A taken item sits in the input
// register; when the result register is empty or being read, the next-time logic
// updates the time registers and loads the result register. The block sustains
// one item per cycle while every result is accepted; the update of the time
// registers from their own value is the loop that sets that rate. After reset
// the time is 0000-01-01 00:00:00.

module calendar_clock_up_down_top
  import ccud_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [TIME_W-1:0] s_tdata,   // load year, month, day, hour, minute, second
  input  logic [OP_W-1:0]   s_tuser,   // op
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [TIME_W-1:0] m_tdata,   // cur year, month, day, hour, minute, second
  output logic              m_tuser    // accepted
);

  logic  in_valid;
  op_t   in_op;
  time_t in_load;
  time_t now;
  time_t now_next;
  logic  acc_next;
  logic  adv;
  logic  take;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_op          <= op_t'(s_tuser);
      in_load.year   <= s_tdata[13:0];
      in_load.month  <= s_tdata[17:14];
      in_load.day    <= s_tdata[22:18];
      in_load.hour   <= s_tdata[27:23];
      in_load.minute <= s_tdata[33:28];
      in_load.second <= s_tdata[39:34];
    end
  end

  ccud_step u_step (
    .cur      (now),
    .op       (in_op),
    .load     (in_load),
    .nxt      (now_next),
    .accepted (acc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      now.year   <= '0;
      now.month  <= MONTH_FIRST;
      now.day    <= DAY_FIRST;
      now.hour   <= '0;
      now.minute <= '0;
      now.second <= '0;
    end else if (adv) begin
      now <= now_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {now_next.second, now_next.minute, now_next.hour,
                  now_next.day, now_next.month, now_next.year};
      m_tuser <= acc_next;
    end
  end

`ifndef SYNTHESIS
  a_time_legal: assert property (@(posedge clk) disable iff (rst)
    (now.second <= SECOND_LAST) && (now.minute <= MINUTE_LAST) &&
    (now.hour <= HOUR_LAST) && (now.day >= DAY_FIRST) &&
    (now.month >= MONTH_FIRST) && (now.month <= MONTH_LAST) &&
    (now.year <= YEAR_MAX))
    else $error("time registers hold an illegal time");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    adv && !acc_next |=> $stable(now))
    else $error("rejected item changed the time");

  a_adv_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_tvalid)
    else $error("item advanced without a result");

  a_item_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !adv |=> in_valid)
    else $error("held item dropped");

  a_no_move_idle: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(now))
    else $error("time changed with no item");
`endif

endmodule

>>> verif/tb_top.sv
// testbench for the calendar clock: loads and one-second steps, every result checked
`timescale 1ns / 1ps

module tb_top;
  import ccud_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 10;

  localparam int MONTH_LSB  = YEAR_W;
  localparam int DAY_LSB    = MONTH_LSB + MONTH_W;
  localparam int HOUR_LSB   = DAY_LSB + DAY_W;
  localparam int MINUTE_LSB = HOUR_LSB + HOUR_W;
  localparam int SECOND_LSB = MINUTE_LSB + MINUTE_W;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic                acc;
  } clock_reading_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [TIME_W-1:0] s_tdata;
  logic [OP_W-1:0]   s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [TIME_W-1:0] m_tdata;
  logic              m_tuser;

  clock_reading_t expected_readings[$];
  int unsigned    cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second;
  int unsigned    mismatch_count = 0;
  int unsigned    stall_cycles = 0;
  int unsigned    items_sent = 0;
  bit             tx_idle_en = 1'b1;
  bit             rx_idle_en = 1'b1;
  bit             rx_hold_req = 1'b0;

  calendar_clock_up_down_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_of(int unsigned y, int unsigned m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic void advance_second();
    if (cal_second < SECOND_LAST) begin
      cal_second++;
      return;
    end
    cal_second = 0;
    if (cal_minute < MINUTE_LAST) begin
      cal_minute++;
      return;
    end
    cal_minute = 0;
    if (cal_hour < HOUR_LAST) begin
      cal_hour++;
      return;
    end
    cal_hour = 0;
    if (cal_day < days_of(cal_year, cal_month)) begin
      cal_day++;
      return;
    end
    cal_day = 1;
    if (cal_month < MONTH_LAST) begin
      cal_month++;
      return;
    end
    cal_month = 1;
    cal_year = (cal_year >= YEAR_MAX) ? 0 : cal_year + 1;
  endfunction

  function automatic void retreat_second();
    if (cal_second > 0) begin
      cal_second--;
      return;
    end
    cal_second = 32'(SECOND_LAST);
    if (cal_minute > 0) begin
      cal_minute--;
      return;
    end
    cal_minute = 32'(MINUTE_LAST);
    if (cal_hour > 0) begin
      cal_hour--;
      return;
    end
    cal_hour = 32'(HOUR_LAST);
    if (cal_day > 1) begin
      cal_day--;
      return;
    end
    if (cal_month > 1) begin
      cal_month--;
    end else begin
      cal_month = 32'(MONTH_LAST);
      cal_year = (cal_year == 0) ? 32'(YEAR_MAX) : cal_year - 1;
    end
    cal_day = days_of(cal_year, cal_month);
  endfunction

  function automatic clock_reading_t predict_reading(op_t op, int unsigned ly, int unsigned lmo,
                                                     int unsigned ld, int unsigned lh,
                                                     int unsigned lmi, int unsigned ls);
    clock_reading_t r;
    bit             acc;
    acc = 1'b0;
    case (op)
      OP_LOAD: begin
        if (ly <= YEAR_MAX && lmo >= 1 && lmo <= MONTH_LAST && ld >= 1 &&
            ld <= days_of(ly, lmo) && lh <= HOUR_LAST && lmi <= MINUTE_LAST &&
            ls <= SECOND_LAST) begin
          cal_year   = ly;
          cal_month  = lmo;
          cal_day    = ld;
          cal_hour   = lh;
          cal_minute = lmi;
          cal_second = ls;
          acc = 1'b1;
        end
      end
      OP_BACK: begin
        retreat_second();
        acc = 1'b1;
      end
      OP_FWD: begin
        advance_second();
        acc = 1'b1;
      end
      default: ;
    endcase
    r.year   = cal_year[YEAR_W-1:0];
    r.month  = cal_month[MONTH_W-1:0];
    r.day    = cal_day[DAY_W-1:0];
    r.hour   = cal_hour[HOUR_W-1:0];
    r.minute = cal_minute[MINUTE_W-1:0];
    r.second = cal_second[SECOND_W-1:0];
    r.acc    = acc;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_item(op_t op, int unsigned ly, int unsigned lmo, int unsigned ld,
                           int unsigned lh, int unsigned lmi, int unsigned ls);
    int unsigned gap;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {ls[SECOND_W-1:0], lmi[MINUTE_W-1:0], lh[HOUR_W-1:0],
                ld[DAY_W-1:0], lmo[MONTH_W-1:0], ly[YEAR_W-1:0]};
    do @(posedge clk); while (!s_tready);
    expected_readings.push_back(predict_reading(op, 32'(ly[YEAR_W-1:0]),
                                                32'(lmo[MONTH_W-1:0]),
                                                32'(ld[DAY_W-1:0]), 32'(lh[HOUR_W-1:0]),
                                                32'(lmi[MINUTE_W-1:0]),
                                                32'(ls[SECOND_W-1:0])));
    items_sent++;
    gap = tx_idle_en ? idle_len() : 0;
    if (gap != 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata  = TIME_W'({$urandom(), $urandom()});
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drop tvalid before any wait so the last item is not taken again
  task automatic stop_sending();
    if (s_tvalid) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
  endtask

  // every load field random over its full width
  task automatic send_raw(op_t op);
    send_item(op, $urandom_range(0, (1 << YEAR_W) - 1), $urandom_range(0, (1 << MONTH_W) - 1),
              $urandom_range(0, (1 << DAY_W) - 1), $urandom_range(0, (1 << HOUR_W) - 1),
              $urandom_range(0, (1 << MINUTE_W) - 1), $urandom_range(0, (1 << SECOND_W) - 1));
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_reading();
    clock_reading_t want;
    if (expected_readings.size() == 0) begin
      mismatch_count++;
      $display("%0t: result with no item pending, actual %h / %b", $time, m_tdata, m_tuser);
      return;
    end
    want = expected_readings.pop_front();
    compare_field("year", 32'(want.year), 32'(m_tdata[YEAR_W-1:0]));
    compare_field("month", 32'(want.month), 32'(m_tdata[MONTH_LSB +: MONTH_W]));
    compare_field("day", 32'(want.day), 32'(m_tdata[DAY_LSB +: DAY_W]));
    compare_field("hour", 32'(want.hour), 32'(m_tdata[HOUR_LSB +: HOUR_W]));
    compare_field("minute", 32'(want.minute), 32'(m_tdata[MINUTE_LSB +: MINUTE_W]));
    compare_field("second", 32'(want.second), 32'(m_tdata[SECOND_LSB +: SECOND_W]));
    compare_field("accepted", 32'(want.acc), 32'(m_tuser));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (m_tvalid && m_tready) check_reading();
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      if (stall_left == 0 && rx_idle_en && $urandom_range(0, 99) < 25) stall_left = idle_len();
      if (stall_left != 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  task automatic test_reset_steps();
    send_raw(OP_FWD);
    send_raw(OP_BACK);
    send_raw(OP_BACK);
    send_raw(OP_FWD);
  endtask

  task automatic test_load_checks();
    send_item(OP_LOAD, YEAR_MAX, 12, 31, 23, 59, 59);
    send_item(OP_LOAD, 10000, 1, 1, 0, 0, 0);
    send_item(OP_LOAD, 16383, 6, 15, 12, 30, 30);
    send_item(OP_LOAD, 2020, 0, 1, 0, 0, 0);
    send_item(OP_LOAD, 2020, 13, 1, 0, 0, 0);
    send_item(OP_LOAD, 2020, 5, 0, 0, 0, 0);
    send_item(OP_LOAD, 2023, 4, 31, 0, 0, 0);
    send_item(OP_LOAD, 1900, 2, 29, 0, 0, 0);
    send_item(OP_LOAD, 2000, 2, 30, 0, 0, 0);
    send_item(OP_LOAD, 2020, 7, 4, 24, 0, 0);
    send_item(OP_LOAD, 2020, 7, 4, 0, 60, 0);
    send_item(OP_LOAD, 2020, 7, 4, 0, 0, 60);
  endtask

  task automatic test_rollover();
    send_item(OP_LOAD, 2000, 2, 28, 23, 59, 59);
    send_raw(OP_FWD);
    send_item(OP_LOAD, 1900, 2, 28, 23, 59, 59);
    send_raw(OP_FWD);
    send_item(OP_LOAD, 0, 3, 1, 0, 0, 0);
    send_raw(OP_BACK);
    send_item(OP_LOAD, 2023, 4, 30, 23, 59, 59);
    send_raw(OP_FWD);
  endtask

  task automatic test_unused_op();
    send_raw(OP_NONE);
  endtask

  // boundary loads followed by bursts of steps, with some noise mixed in
  task automatic test_random_walk(int unsigned n_items);
    int unsigned start, sel, mode, y, mo, d, h, mi, s;
    bit          near_end;
    op_t         dir;
    start = items_sent;
    while (items_sent - start < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        case ($urandom_range(0, 7))
          0:       y = 0;
          1:       y = YEAR_MAX;
          2:       y = 1900;
          3:       y = 2000;
          4:       y = 2100;
          5:       y = 2400;
          6:       y = $urandom_range(0, 2499) * 4;
          default: y = $urandom_range(0, YEAR_MAX);
        endcase
        case ($urandom_range(0, 5))
          0, 1:    mo = 2;
          2:       mo = 12;
          3:       mo = 1;
          default: mo = $urandom_range(1, 12);
        endcase
        near_end = 1'($urandom_range(0, 1));
        if (near_end) begin
          d = days_of(y, mo);
          h = HOUR_LAST;
          mi = MINUTE_LAST;
          s = $urandom_range(48, SECOND_LAST);
        end else begin
          d = 1;
          h = 0;
          mi = 0;
          s = $urandom_range(0, 11);
        end
        if ($urandom_range(0, 3) == 0) h = $urandom_range(0, HOUR_LAST);
        if ($urandom_range(0, 3) == 0) mi = $urandom_range(0, MINUTE_LAST);
        send_item(OP_LOAD, y, mo, d, h, mi, s);
        dir = (near_end ^ ($urandom_range(0, 99) < 20)) ? OP_FWD : OP_BACK;
        mode = $urandom_range(0, 9);
        repeat ($urandom_range(1, 12)) begin
          if (mode == 0) send_raw(($urandom_range(0, 1) != 0) ? OP_FWD : OP_BACK);
          else send_raw(dir);
        end
      end else if (sel < 85) begin
        send_raw(OP_LOAD);
        repeat ($urandom_range(0, 3)) send_raw(($urandom_range(0, 1) != 0) ? OP_FWD : OP_BACK);
      end else if (sel < 95) begin
        y = $urandom_range(0, YEAR_MAX);
        mo = $urandom_range(1, 12);
        send_item(OP_LOAD, y, mo, $urandom_range(1, days_of(y, mo)), $urandom_range(0, HOUR_LAST),
                  $urandom_range(0, MINUTE_LAST), $urandom_range(0, SECOND_LAST));
        repeat ($urandom_range(1, 4)) send_raw(($urandom_range(0, 1) != 0) ? OP_FWD : OP_BACK);
      end else begin
        send_raw(OP_NONE);
      end
    end
  endtask

  task automatic test_full_rate(int unsigned n_items);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_walk(n_items);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_hold_req = 1'b1;
    test_random_walk(30);
    stop_sending();
    wait (!rx_hold_req);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    test_random_walk(300);
    stop_sending();
    while (expected_readings.size() != 0) @(posedge clk);
    test_random_walk(300);
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = OP_NONE;
    cal_year   = 0;
    cal_month  = 1;
    cal_day    = 1;
    cal_hour   = 0;
    cal_minute = 0;
    cal_second = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_steps();
    test_load_checks();
    test_rollover();
    test_unused_op();
    test_random_walk(1000);
    test_full_rate(250);
    test_backpressure();
    test_drain_pause();

    stop_sending();
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> calendar_clock_up_down_top.f
sv/ccud_pkg.sv
sv/ccud_step.sv
sv/calendar_clock_up_down_top.sv
verif/tb_top.sv
